/* design/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types and constants for the PCX RLE image decoder.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  // header layout
  localparam int HEADER_BYTES  = 128;
  localparam int HPOS_W        = $clog2(HEADER_BYTES);
  localparam int POS_BPP       = 3;
  localparam int POS_BOUND_LO  = 4;
  localparam int POS_BOUND_HI  = 11;
  localparam int POS_PLANES    = 65;

  localparam logic [7:0] BPP_SUPPORTED    = 8'd8;
  localparam logic [7:0] PLANES_SUPPORTED = 8'd1;

  // window bound slots
  localparam int BOUND_W   = 16;
  localparam int BOUND_N   = 4;
  localparam int BND_XMIN  = 0;
  localparam int BND_YMIN  = 1;
  localparam int BND_XMAX  = 2;
  localparam int BND_YMAX  = 3;

  // sizes
  localparam int DIM_W      = 17;
  localparam int PIX_CNT_W  = 33;
  localparam int ALU_W      = 34;
  localparam int MUL_STEPS  = DIM_W;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
  localparam int RUN_W      = 6;

  // top two bits set marks a run byte (value 192 and up)
  localparam logic [1:0] RUN_MARK = 2'b11;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_UNSUP  = 2'd1,
    KIND_PIXEL  = 2'd2
  } item_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    SQ_WAIT,
    SQ_WSUB,
    SQ_WINC,
    SQ_HSUB,
    SQ_HINC,
    SQ_MUL,
    SQ_HDR_OUT,
    SQ_EMIT
  } seq_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

/* design/pcxrle_alu.sv */
// ----------------------------------------------------------------------------
// pcxrle_alu
// Shared add/subtract unit; subtract result is negative when bit ALU_W-1 set.
// ----------------------------------------------------------------------------
module pcxrle_alu import pcxrle_pkg::*; (
  input  alu_op_t          op,
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] sum
);

  always_comb begin
    unique case (op)
      ALU_ADD: sum = a + b;
      ALU_SUB: sum = a + ~b + ALU_W'(1);
      default: sum = a + b;
    endcase
  end

endmodule

/* design/pcx_rle_image_decoder_top.sv */
// ----------------------------------------------------------------------------
// pcx_rle_image_decoder_top
// PCX 8 bpp single-plane decoder: header parse, size check, RLE expansion.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                                     | tuser / tlast
//  --------+-----+-------------------------------------------+---------------------------
//  in_     | in  | [7:0] file_byte                           | tuser: first_byte
//  out_    | out | [7:0] pixel_value, [24:8] image_width,    | tuser: [1:0] item_kind,
//          |     | [41:25] image_height, [47:42] zero        | [2] image_end; tlast: run_last
//
//  Header and ignored bytes are accepted as they come. A literal pixel byte
//  is accepted, then loads the output register. A run byte pair accepts
//  both bytes, then loads the output register once per emitted pixel (up
//  to 63). The last header byte starts the size calculation (width, then
//  height: subtract, then increment) and, for a supported image only, a
//  shift-add multiply for the pixel count, all on the one shared adder,
//  then posts the header word. in_tready is low while the sequencer is
//  busy and while a result waits for a free output register.
//  Reset (rst_n low, synchronous) returns to idle; bytes before the first
//  word marked by in_tuser are dropped.
//
module pcx_rle_image_decoder_top import pcxrle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] file_byte
  input  logic        in_tuser,    // [0] first_byte

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [7:0] pixel_value, [24:8] image_width,
                                   // [41:25] image_height, [47:42] zero
  output logic [2:0]  out_tuser,   // [1:0] item_kind, [2] image_end
  output logic        out_tlast    // run_last
);

  // control state
  seq_t                  seq_r, seq_nxt;
  phase_t                phase_r, phase_nxt;
  logic [HPOS_W-1:0]     hpos_r, hpos_nxt;
  logic                  run_pend_r, run_pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MUL_CNT_W-1:0]  mul_cnt_r, mul_cnt_nxt;
  logic [RUN_W-1:0]      cnt_r, cnt_nxt;

  // datapath state
  logic [7:0]            bpp_r, bpp_nxt;
  logic [7:0]            planes_r, planes_nxt;
  logic [BOUND_W-1:0]    bounds_r [BOUND_N];
  logic [BOUND_W-1:0]    bounds_nxt [BOUND_N];
  logic [RUN_W-1:0]      run_len_r, run_len_nxt;
  logic [PIX_CNT_W-1:0]  remain_r, remain_nxt;
  logic [PIX_CNT_W-1:0]  mcand_r, mcand_nxt;
  logic [DIM_W-1:0]      mplier_r, mplier_nxt;
  logic [DIM_W-1:0]      width_r, width_nxt;
  logic [DIM_W-1:0]      height_r, height_nxt;
  logic                  bad_r, bad_nxt;
  logic [7:0]            pix_r, pix_nxt;

  // output register
  item_kind_t            o_kind_r, o_kind_nxt;
  logic [7:0]            o_pix_r, o_pix_nxt;
  logic [DIM_W-1:0]      o_w_r, o_w_nxt;
  logic [DIM_W-1:0]      o_h_r, o_h_nxt;
  logic                  o_last_r, o_last_nxt;
  logic                  o_end_r, o_end_nxt;

  // shared adder
  alu_op_t               alu_op;
  logic [ALU_W-1:0]      alu_a, alu_b, alu_sum;

  logic                  in_acc;
  logic                  slot_free;
  phase_t                eff_phase;
  logic [HPOS_W-1:0]     eff_pos;
  logic [HPOS_W-1:0]     pos_off;
  logic                  rem_zero;
  logic                  last_px;

  pcxrle_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum)
  );

  assign in_tready = (seq_r == SQ_WAIT);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // a marked word restarts the file as header byte 0
  assign eff_phase = in_tuser ? PH_HEADER : phase_r;
  assign eff_pos   = in_tuser ? '0 : hpos_r;
  assign pos_off   = eff_pos - HPOS_W'(POS_BOUND_LO);

  assign rem_zero  = (alu_sum[PIX_CNT_W-1:0] == '0);
  assign last_px   = (cnt_r == RUN_W'(1)) || rem_zero;

  // adder operand select
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = ALU_W'(remain_r);
    alu_b  = ALU_W'(mcand_r);
    unique case (seq_r)
      SQ_WSUB: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(bounds_r[BND_XMAX]);
        alu_b  = ALU_W'(bounds_r[BND_XMIN]);
      end
      SQ_WINC: begin
        alu_a = ALU_W'(width_r);
        alu_b = ALU_W'(1);
      end
      SQ_HSUB: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(bounds_r[BND_YMAX]);
        alu_b  = ALU_W'(bounds_r[BND_YMIN]);
      end
      SQ_HINC: begin
        alu_a = ALU_W'(height_r);
        alu_b = ALU_W'(1);
      end
      SQ_EMIT: begin
        alu_op = ALU_SUB;
        alu_b  = ALU_W'(1);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // sequencer
  always_comb begin
    seq_nxt       = seq_r;
    phase_nxt     = phase_r;
    hpos_nxt      = hpos_r;
    run_pend_nxt  = run_pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_cnt_nxt   = mul_cnt_r;
    cnt_nxt       = cnt_r;
    bpp_nxt       = bpp_r;
    planes_nxt    = planes_r;
    bounds_nxt    = bounds_r;
    run_len_nxt   = run_len_r;
    remain_nxt    = remain_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    bad_nxt       = bad_r;
    pix_nxt       = pix_r;
    o_kind_nxt    = o_kind_r;
    o_pix_nxt     = o_pix_r;
    o_w_nxt       = o_w_r;
    o_h_nxt       = o_h_r;
    o_last_nxt    = o_last_r;
    o_end_nxt     = o_end_r;

    unique case (seq_r)
      SQ_WAIT: begin
        if (in_acc) begin
          if (in_tuser) begin
            phase_nxt    = PH_HEADER;
            run_pend_nxt = 1'b0;
          end
          unique case (eff_phase)
            PH_HEADER: begin
              if (eff_pos == HPOS_W'(POS_BPP)) begin
                bpp_nxt = in_tdata;
              end else if (eff_pos == HPOS_W'(POS_PLANES)) begin
                planes_nxt = in_tdata;
              end else if (eff_pos >= HPOS_W'(POS_BOUND_LO) &&
                           eff_pos <= HPOS_W'(POS_BOUND_HI)) begin
                if (pos_off[0]) begin
                  bounds_nxt[pos_off[2:1]][15:8] = in_tdata;
                end else begin
                  bounds_nxt[pos_off[2:1]][7:0] = in_tdata;
                end
              end
              if (eff_pos == HPOS_W'(HEADER_BYTES - 1)) begin
                seq_nxt = SQ_WSUB;
                bad_nxt = 1'b0;
              end else begin
                hpos_nxt = eff_pos + HPOS_W'(1);
              end
            end
            PH_DATA: begin
              if (run_pend_r) begin
                run_pend_nxt = 1'b0;
                run_len_nxt  = '0;
                if (run_len_r != '0) begin
                  cnt_nxt = run_len_r;
                  pix_nxt = ~in_tdata;
                  seq_nxt = SQ_EMIT;
                end
              end else if (in_tdata[7:6] == RUN_MARK) begin
                run_len_nxt  = in_tdata[RUN_W-1:0];
                run_pend_nxt = 1'b1;
              end else begin
                cnt_nxt = RUN_W'(1);
                pix_nxt = ~in_tdata;
                seq_nxt = SQ_EMIT;
              end
            end
            default: begin
              // idle or finished: word dropped
            end
          endcase
        end
      end

      SQ_WSUB: begin
        width_nxt = alu_sum[DIM_W-1:0];
        if (alu_sum[ALU_W-1]) begin
          bad_nxt = 1'b1;
        end
        seq_nxt = SQ_WINC;
      end

      SQ_WINC: begin
        width_nxt = alu_sum[DIM_W-1:0];
        seq_nxt   = SQ_HSUB;
      end

      SQ_HSUB: begin
        height_nxt = alu_sum[DIM_W-1:0];
        if (alu_sum[ALU_W-1]) begin
          bad_nxt = 1'b1;
        end
        seq_nxt = SQ_HINC;
      end

      SQ_HINC: begin
        height_nxt = alu_sum[DIM_W-1:0];
        if (bad_r || bpp_r != BPP_SUPPORTED || planes_r != PLANES_SUPPORTED) begin
          bad_nxt = 1'b1;
          seq_nxt = SQ_HDR_OUT;
        end else begin
          remain_nxt  = '0;
          mcand_nxt   = PIX_CNT_W'(width_r);
          mplier_nxt  = alu_sum[DIM_W-1:0];
          mul_cnt_nxt = MUL_CNT_W'(MUL_STEPS - 1);
          seq_nxt     = SQ_MUL;
        end
      end

      SQ_MUL: begin
        // one shift-add step per cycle
        if (mplier_r[0]) begin
          remain_nxt = alu_sum[PIX_CNT_W-1:0];
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        mul_cnt_nxt = mul_cnt_r - MUL_CNT_W'(1);
        if (mul_cnt_r == '0) begin
          seq_nxt = SQ_HDR_OUT;
        end
      end

      SQ_HDR_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_pix_nxt     = '0;
          o_last_nxt    = 1'b1;
          o_end_nxt     = 1'b0;
          run_pend_nxt  = 1'b0;
          run_len_nxt   = '0;
          if (bad_r) begin
            o_kind_nxt = KIND_UNSUP;
            o_w_nxt    = '0;
            o_h_nxt    = '0;
            phase_nxt  = PH_DONE;
          end else begin
            o_kind_nxt = KIND_HEADER;
            o_w_nxt    = width_r;
            o_h_nxt    = height_r;
            phase_nxt  = PH_DATA;
          end
          seq_nxt = SQ_WAIT;
        end
      end

      SQ_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = KIND_PIXEL;
          o_pix_nxt     = pix_r;
          o_w_nxt       = '0;
          o_h_nxt       = '0;
          o_last_nxt    = last_px;
          o_end_nxt     = rem_zero;
          remain_nxt    = alu_sum[PIX_CNT_W-1:0];
          cnt_nxt       = cnt_r - RUN_W'(1);
          if (last_px) begin
            seq_nxt = SQ_WAIT;
          end
          if (rem_zero) begin
            phase_nxt = PH_DONE;
          end
        end
      end

      default: begin
        seq_nxt = SQ_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SQ_WAIT;
      phase_r     <= PH_IDLE;
      hpos_r      <= '0;
      run_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mul_cnt_r   <= '0;
      cnt_r       <= '0;
    end else begin
      seq_r       <= seq_nxt;
      phase_r     <= phase_nxt;
      hpos_r      <= hpos_nxt;
      run_pend_r  <= run_pend_nxt;
      out_valid_r <= out_valid_nxt;
      mul_cnt_r   <= mul_cnt_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bpp_r     <= bpp_nxt;
    planes_r  <= planes_nxt;
    bounds_r  <= bounds_nxt;
    run_len_r <= run_len_nxt;
    remain_r  <= remain_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    width_r   <= width_nxt;
    height_r  <= height_nxt;
    bad_r     <= bad_nxt;
    pix_r     <= pix_nxt;
    o_kind_r  <= o_kind_nxt;
    o_pix_r   <= o_pix_nxt;
    o_w_r     <= o_w_nxt;
    o_h_r     <= o_h_nxt;
    o_last_r  <= o_last_nxt;
    o_end_r   <= o_end_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, o_h_r, o_w_r, o_pix_r};
  assign out_tuser  = {o_end_r, o_kind_r};
  assign out_tlast  = o_last_r;

`ifndef SYNTH
  // pixel expansion only runs with pixels still owed
  a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_EMIT) |-> (phase_r == PH_DATA && remain_r != '0))
    else $error("pixel emission with no pixels remaining");

  // the image-end pixel always closes its input word
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> out_tlast)
    else $error("image end without run_last");

  // pixel count is only multiplied for a supported header
  a_mul_good_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_MUL) |-> !bad_r)
    else $error("multiply running on unsupported header");

  // after the image completes, no pixel word is loaded
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE && seq_r == SQ_WAIT) |=> (seq_r != SQ_EMIT))
    else $error("pixel emission after image end");
`endif

endmodule
